@@ design/gfir_pkg.sv @@
// Shared types, sizes and tap coefficients for the 15-tap Gaussian smoother.
// No dependencies; every other design file imports this package.
package gfir_pkg;

   localparam int SAMPLE_BITS         = 16;
   localparam int COEF_FRAC_BITS_DEF  = 16;
   localparam int TAPS                = 15;
   localparam int HIST                = TAPS - 1;
   localparam int HALF                = (TAPS - 1) / 2;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   is_final;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] smoothed;
      logic                   end_of_map;
   } rsp_type;

   // One full 15-sample window handed from the window stage to the MAC stages.
   typedef struct packed {
      logic                              valid;
      logic                              last;
      logic [TAPS-1:0][SAMPLE_BITS-1:0]  samples;
   } win_item_type;

   // Kernel half in millionths, outer tap first, center tap last.
   function automatic longint unsigned tap_coef(input int unsigned idx,
                                                input int unsigned frac);
      longint unsigned micro;
      case (idx)
         0:       micro = 64'd9033;
         1:       micro = 64'd18476;
         2:       micro = 64'd33851;
         3:       micro = 64'd55555;
         4:       micro = 64'd81670;
         5:       micro = 64'd107545;
         6:       micro = 64'd126854;
         7:       micro = 64'd134032;
         default: micro = 64'd0;
      endcase
      // round half up to Qx.frac
      return ((micro << frac) + 64'd500000) / 64'd1000000;
   endfunction

endpackage

@@ design/gaussian_fir15_same_length_top.sv @@
// Streaming 15-tap Gaussian smoother with same-length output. Each request is
// one unsigned sample plus an is_final flag; a map of L samples yields exactly
// L responses, each the symmetric kernel sum centered on one sample with zero
// padding at both map ends, truncated by COEF_FRAC_BITS and clamped to 16 bits.
// The first seven requests of a map produce nothing yet; the final request
// releases all pending responses (up to eight), one per cycle unless the
// output stalls, and the port stalls new requests while that flush runs.
// Otherwise one request is taken every cycle unless the output stalls.
// Results pass the window, multiply, partial-sum and output registers.
// Depends on gfir_pkg, gfir_front and gfir_mac.
module gaussian_fir15_same_length_top
   import gfir_pkg::*;
#(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   win_item_type win_item;
   logic         win_ready;

   gfir_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .win_ready (win_ready),
      .win_item  (win_item)
   );

   gfir_mac #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .win_item  (win_item),
      .win_ready (win_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/gfir_front.sv @@
// Sample window, pending count and end-of-map flush sequencer.
// Depends on gfir_pkg; feeds full windows to gfir_mac.
module gfir_front
   import gfir_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  logic         win_ready,
   output win_item_type win_item
);

   localparam int CNT_BITS = $clog2(HALF + 1);
   localparam int IDX_BITS = $clog2(TAPS);
   localparam int SUM_BITS = $clog2(TAPS + HALF + 1);

   logic [HIST-1:0][SAMPLE_BITS-1:0] window_ff, window_in;
   logic [TAPS-1:0][SAMPLE_BITS-1:0] flush_ff, flush_in;
   logic [CNT_BITS-1:0]              pend_ff, pend_in;
   logic [CNT_BITS-1:0]              flush_cnt_ff, flush_cnt_in;
   win_item_type                     item_ff, item_in;

   logic                             load_win;
   logic                             flushing;
   logic                             accept;
   logic [TAPS-1:0][SAMPLE_BITS-1:0] buf_new;
   logic [TAPS-1:0][SAMPLE_BITS-1:0] pre;
   logic [CNT_BITS-1:0]              pad;
   logic [SUM_BITS-1:0]              idx;

   always_comb begin
      load_win  = !item_ff.valid || win_ready;
      flushing  = flush_cnt_ff != '0;
      req_stall = flushing || !load_win;
      accept    = req_valid && !req_stall;

      buf_new = {req_data.sample, window_ff};

      // Final request: pad with zeros so the window sits at the first
      // still-pending center.
      pad = CNT_BITS'(HALF) - pend_ff;
      for (int i = 0; i < TAPS; i++) begin
         idx    = SUM_BITS'(i) + SUM_BITS'(pad);
         pre[i] = (idx <= SUM_BITS'(HIST)) ? buf_new[idx[IDX_BITS-1:0]] : '0;
      end

      window_in    = window_ff;
      pend_in      = pend_ff;
      flush_in     = flush_ff;
      flush_cnt_in = flush_cnt_ff;
      item_in      = item_ff;
      if (load_win) begin
         item_in.valid = 1'b0;
      end

      if (flushing && load_win) begin
         item_in.valid   = 1'b1;
         item_in.last    = flush_cnt_ff == CNT_BITS'(1);
         item_in.samples = flush_ff;
         flush_in        = {SAMPLE_BITS'(0), flush_ff[TAPS-1:1]};
         flush_cnt_in    = flush_cnt_ff - CNT_BITS'(1);
      end else if (accept) begin
         if (!req_data.is_final) begin
            window_in = buf_new[TAPS-1:1];
            if (pend_ff == CNT_BITS'(HALF)) begin
               item_in.valid   = 1'b1;
               item_in.last    = 1'b0;
               item_in.samples = buf_new;
            end else begin
               pend_in = pend_ff + CNT_BITS'(1);
            end
         end else begin
            item_in.valid   = 1'b1;
            item_in.last    = pend_ff == '0;
            item_in.samples = pre;
            flush_in        = {SAMPLE_BITS'(0), pre[TAPS-1:1]};
            flush_cnt_in    = pend_ff;
            window_in       = '0;
            pend_in         = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      flush_ff <= flush_in;
      if (reset) begin
         window_ff    <= '0;
         pend_ff      <= '0;
         flush_cnt_ff <= '0;
         item_ff      <= '0;
      end else begin
         window_ff    <= window_in;
         pend_ff      <= pend_in;
         flush_cnt_ff <= flush_cnt_in;
         item_ff      <= item_in;
      end
   end

   assign win_item = item_ff;

endmodule

@@ design/gfir_mac.sv @@
// Folded multiply, partial sums, truncate and saturate: three register stages.
// Depends on gfir_pkg; takes windows from gfir_front, drives the response port.
module gfir_mac
   import gfir_pkg::*;
#(
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  win_item_type win_item,
   output logic         win_ready,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   // Largest tap is below 0.25, so its top two fraction bits are always zero.
   localparam int COEF_BITS = COEF_FRAC_BITS - 2;
   localparam int PROD_BITS = SAMPLE_BITS + COEF_FRAC_BITS - 1;
   localparam int ACC_BITS  = SAMPLE_BITS + COEF_FRAC_BITS + 1;
   localparam int NPROD     = HALF + 1;
   localparam int NPART     = (NPROD + 1) / 2;

   logic [NPROD-1:0][PROD_BITS-1:0] prod_ff, prod_in;
   logic                            b_valid_ff, b_last_ff;
   logic [NPART-1:0][ACC_BITS-1:0]  part_ff, part_in;
   logic                            c_valid_ff, c_last_ff;
   rsp_type                         rsp_ff, rsp_in;
   logic                            d_valid_ff;

   logic                            load_b, load_c, load_d;
   logic [ACC_BITS-1:0]             total;

   always_comb begin
      load_d    = !d_valid_ff || !rsp_stall;
      load_c    = !c_valid_ff || load_d;
      load_b    = !b_valid_ff || load_c;
      win_ready = load_b;
   end

   for (genvar j = 0; j < NPROD; j++) begin : g_lane
      localparam logic [COEF_BITS-1:0] Coef = COEF_BITS'(tap_coef(j, COEF_FRAC_BITS));
      logic [SAMPLE_BITS:0] fold;
      if (j < HALF) begin : g_pair
         assign fold = {1'b0, win_item.samples[j]} + {1'b0, win_item.samples[TAPS-1-j]};
      end else begin : g_center
         assign fold = {1'b0, win_item.samples[j]};
      end
      assign prod_in[j] = PROD_BITS'(fold) * PROD_BITS'(Coef);
   end

   always_comb begin
      for (int m = 0; m < NPART; m++) begin
         part_in[m] = ACC_BITS'(prod_ff[2*m]);
         if (2*m + 1 < NPROD) begin
            part_in[m] = part_in[m] + ACC_BITS'(prod_ff[2*m+1]);
         end
      end

      total = '0;
      for (int m = 0; m < NPART; m++) begin
         total = total + part_ff[m];
      end

      rsp_in.end_of_map = c_last_ff;
      if (|total[ACC_BITS-1:COEF_FRAC_BITS+SAMPLE_BITS]) begin
         rsp_in.smoothed = '1;
      end else begin
         rsp_in.smoothed = total[COEF_FRAC_BITS+SAMPLE_BITS-1:COEF_FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (load_b) begin
         prod_ff   <= prod_in;
         b_last_ff <= win_item.last;
      end
      if (load_c) begin
         part_ff   <= part_in;
         c_last_ff <= b_last_ff;
      end
      if (load_d) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (load_b) b_valid_ff <= win_item.valid;
         if (load_c) c_valid_ff <= b_valid_ff;
         if (load_d) d_valid_ff <= c_valid_ff;
      end
   end

   assign rsp_valid = d_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/gfir_checker.sv @@
// Port-level checks for the Gaussian smoother, bound onto the top level.
// Depends on gfir_pkg and gaussian_fir15_same_length_top.
module gfir_checker
   import gfir_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Seven pending samples plus four pipeline registers.
   localparam int MAX_OUT  = HALF + 4;
   localparam int OUT_BITS = $clog2(MAX_OUT + 2);

   logic                req_take, rsp_take;
   logic [OUT_BITS-1:0] samp_out_ff, samp_out_in;
   logic [OUT_BITS-1:0] fin_out_ff, fin_out_in;

   always_comb begin
      req_take    = req_valid && !req_stall;
      rsp_take    = rsp_valid && !rsp_stall;
      samp_out_in = samp_out_ff + OUT_BITS'(req_take) - OUT_BITS'(rsp_take);
      fin_out_in  = fin_out_ff + OUT_BITS'(req_take && req_data.is_final)
                    - OUT_BITS'(rsp_take && rsp_data.end_of_map);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         samp_out_ff <= '0;
         fin_out_ff  <= '0;
      end else begin
         samp_out_ff <= samp_out_in;
         fin_out_ff  <= fin_out_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> samp_out_ff != '0)
      else $error("more responses than requests");

   a_eom_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_data.end_of_map |-> fin_out_ff != '0)
      else $error("end of map without a final request");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      samp_out_ff <= OUT_BITS'(MAX_OUT))
      else $error("too many requests without a response");

endmodule

bind gaussian_fir15_same_length_top gfir_checker u_checker (.*);

@@ tb/smoothing_checker.sv @@
`timescale 1ns / 100ps
// Watches the request and response channels of the Gaussian smoother, predicts
// each map's smoothed values and compares them with the responses. Uses gfir_pkg types.
module smoothing_checker
   import gfir_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      errors,
   output int      outstanding,
   output int      checked
);

   // previous samples of the current map, index 0 oldest
   logic [HIST-1:0][SAMPLE_BITS-1:0] history;
   int backlog;
   int mismatches;
   int compared;
   rsp_type smoothed_q[$];

   // Q0.16 kernel taps, outer tap first, mirrored about the center
   function automatic int unsigned kernel_tap(input int idx);
      int half_idx;
      half_idx = (idx <= HALF) ? idx : TAPS - 1 - idx;
      case (half_idx)
         0:       return 592;
         1:       return 1211;
         2:       return 2218;
         3:       return 3641;
         4:       return 5352;
         5:       return 7048;
         6:       return 8314;
         default: return 8784;
      endcase
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] kernel_sum(
      input logic [TAPS-1:0][SAMPLE_BITS-1:0] span);
      longint unsigned acc;
      longint unsigned max_val;
      acc     = 64'd0;
      max_val = (64'd1 << SAMPLE_BITS) - 64'd1;
      for (int t = 0; t < TAPS; t++)
         acc += 64'(span[t]) * 64'(kernel_tap(t));
      acc = acc >> 16;
      if (acc > max_val)
         acc = max_val;
      return acc[SAMPLE_BITS-1:0];
   endfunction

   task automatic predict_smoothing(input req_type r);
      logic [TAPS-1:0][SAMPLE_BITS-1:0] span;
      int n;
      span = {r.sample, history};
      if (!r.is_final) begin
         if (backlog >= HALF)
            smoothed_q.push_back(rsp_type'{smoothed: kernel_sum(span), end_of_map: 1'b0});
         else
            backlog++;
         history = span[TAPS-1:1];
      end else begin
         // final sample: pad with zeros until every pending sample sits centered
         n = backlog + 1;
         repeat (HALF + 1 - n) span = {{SAMPLE_BITS{1'b0}}, span[TAPS-1:1]};
         for (int s = 0; s < n; s++) begin
            smoothed_q.push_back(rsp_type'{smoothed: kernel_sum(span),
                                           end_of_map: (s == n - 1)});
            span = {{SAMPLE_BITS{1'b0}}, span[TAPS-1:1]};
         end
         history = '0;
         backlog = 0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         history = '0;
         backlog = 0;
         mismatches = 0;
         compared = 0;
         smoothed_q.delete();
      end else begin
         // a response never belongs to a request taken at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (smoothed_q.size() == 0) begin
               mismatches++;
               $error("unexpected response: smoothed %0d end_of_map %0d",
                      rsp_data.smoothed, rsp_data.end_of_map);
            end else begin
               want = smoothed_q.pop_front();
               compared++;
               if (rsp_data.smoothed !== want.smoothed) begin
                  mismatches++;
                  $error("smoothed: expected %0d, got %0d", want.smoothed, rsp_data.smoothed);
               end
               if (rsp_data.end_of_map !== want.end_of_map) begin
                  mismatches++;
                  $error("end_of_map: expected %0d, got %0d",
                         want.end_of_map, rsp_data.end_of_map);
               end
            end
         end
         if (req_valid && !req_stall)
            predict_smoothing(req_data);
      end
      errors      <= mismatches;
      outstanding <= smoothed_q.size();
      checked     <= compared;
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Top of the Gaussian smoother testbench: clock, reset, request and response
// stimulus, and the verdict. Depends on gfir_pkg and smoothing_checker.
module testbench;
   import gfir_pkg::*;

   typedef enum int {NOISE, EXTREMES, NEAR_LEVEL, LOW_LEVEL} pattern_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int errors;
   int outstanding;
   int checked;

   int  samples_sent = 0;
   int  maps_sent    = 0;
   bit  idle_on      = 1'b0;
   bit  hold_request = 1'b0;

   gaussian_fir15_same_length_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   smoothing_checker monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .errors      (errors),
      .outstanding (outstanding),
      .checked     (checked)
   );

   always #10 clock = ~clock;

   initial begin
      #10_000_000;
      $display("[gaussian_fir15_same_length_top] ERROR");
      $finish;
   end

   task automatic send_request(input logic [SAMPLE_BITS-1:0] value, input logic last);
      req_valid <= 1'b1;
      req_data  <= req_type'{sample: value, is_final: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
      if (last)
         maps_sent++;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_map(input int len, input pattern_type pattern);
      logic [SAMPLE_BITS-1:0] value;
      logic [SAMPLE_BITS-1:0] base;
      base = SAMPLE_BITS'($urandom);
      for (int i = 0; i < len; i++) begin
         case (pattern)
            NOISE:      value = SAMPLE_BITS'($urandom);
            EXTREMES:   value = $urandom_range(0, 1) ? '1 : '0;
            NEAR_LEVEL: value = base ^ SAMPLE_BITS'($urandom_range(0, 1023));
            default:    value = SAMPLE_BITS'($urandom_range(0, 255));
         endcase
         send_request(value, i == len - 1);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // response side: random stall bursts, plus one long hold-off on demand
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = 150;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int  pick;
      int  len;
      bit  pressure_done;
      pressure_done = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      // single-sample maps at both extremes
      send_request('1, 1'b1);
      send_request('0, 1'b1);
      // short map, all results at the final sample
      send_request('1, 1'b0);
      send_request('0, 1'b0);
      send_request('1, 1'b1);
      // eight full-scale samples: full flush, both ends padded
      for (int i = 0; i < 8; i++)
         send_request('1, i == 7);
      // pending count saturates, alternating bit patterns
      for (int i = 0; i < 10; i++)
         send_request((i % 2) ? 16'h5555 : 16'hAAAA, i == 9);

      while (samples_sent < 135) begin
         idle_on = (samples_sent < 110) && ($urandom_range(0, 3) != 0);
         if (!pressure_done && samples_sent >= 50) begin
            // long output hold-off while the input keeps streaming
            idle_on = 1'b0;
            hold_request = 1'b1;
            send_map(40, NOISE);
            drain();
            pressure_done = 1'b1;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
               len = $urandom_range(1, 20);
            else if (pick < 8)
               len = $urandom_range(8, 40);
            else
               len = $urandom_range(1, 7);
            send_map(len, pattern_type'($urandom_range(0, 3)));
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Streamed %0d samples in %0d maps (single, short, saturated and long maps)",
               samples_sent, maps_sent);
      $display("with a long output hold-off and a full drain; %0d results compared.", checked);
      if (errors == 0 && outstanding == 0)
         $display("[gaussian_fir15_same_length_top] OK");
      else
         $display("[gaussian_fir15_same_length_top] ERROR");
      $finish;
   end

endmodule

@@ gaussian_fir15_same_length_top.f @@
design/gfir_pkg.sv
design/gfir_front.sv
design/gfir_mac.sv
design/gaussian_fir15_same_length_top.sv
design/gfir_checker.sv
tb/smoothing_checker.sv
tb/testbench.sv
